// ===== rtl/core/ole_pkg.sv =====
`default_nettype none
package ole_pkg;
	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned DATA_WIDTH_DEF = 16;
	localparam int unsigned OP_W = 4;
	localparam int unsigned POS_W = 5;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned ST_W = 3;

	localparam logic [OP_W-1:0] OP_INSERT_AT     = 4'd0;
	localparam logic [OP_W-1:0] OP_DELETE_AT     = 4'd1;
	localparam logic [OP_W-1:0] OP_DELETE_VALUE  = 4'd2;
	localparam logic [OP_W-1:0] OP_DELETE_BEFORE = 4'd3;
	localparam logic [OP_W-1:0] OP_DELETE_ALL    = 4'd4;
	localparam logic [OP_W-1:0] OP_SEARCH        = 4'd5;
	localparam logic [OP_W-1:0] OP_REMOVE_FIRST  = 4'd6;
	localparam logic [OP_W-1:0] OP_REMOVE_LAST   = 4'd7;
	localparam logic [OP_W-1:0] OP_DEDUP         = 4'd8;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
	localparam logic [ST_W-1:0] ST_SINGLE   = 3'd5;

	// per-cycle command broadcast from the sequencer to every cell
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,   // cells above sel_idx take left neighbor, sel_idx takes value
		CELL_COMPACT   // cells at or above sel_idx take right neighbor
	} cell_op_t;
endpackage
`default_nettype wire

// ===== rtl/core/ole_cell.sv =====
`default_nettype none
module ole_cell
	import ole_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned IDX_W = 4
) (
	input  wire                   clk,
	input  wire [IDX_W-1:0]       my_idx,
	input  wire cell_op_t         cell_op,
	input  wire [IDX_W-1:0]       sel_idx,
	input  wire [DATA_WIDTH-1:0]  ins_value,
	input  wire [DATA_WIDTH-1:0]  left_data,
	input  wire [DATA_WIDTH-1:0]  right_data,
	output logic [DATA_WIDTH-1:0] data
);
	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (cell_op)
			CELL_INSERT: begin
				if (my_idx == sel_idx) data_q <= ins_value;
				else if (my_idx > sel_idx) data_q <= left_data;
			end
			CELL_COMPACT: begin
				if (my_idx >= sel_idx) data_q <= right_data;
			end
			default: ;
		endcase
	end

	assign data = data_q;
endmodule
`default_nettype wire

// ===== rtl/core/ole_seq.sv =====
`default_nettype none
module ole_seq
	import ole_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned IDX_W = $clog2(DEPTH),
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire [OP_W-1:0]              op,
	input  wire [POS_W-1:0]             position,
	input  wire [VAL_W-1:0]             value,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [ST_W-1:0]             status,
	output logic [VAL_W-1:0]            data_out,
	output logic [POS_W-1:0]            removed_count,
	output logic [POS_W-1:0]            length_after,
	input  wire [DEPTH*DATA_WIDTH-1:0]  cell_data,
	output cell_op_t                    cell_op,
	output logic [IDX_W-1:0]            sel_idx,
	output logic [DATA_WIDTH-1:0]       ins_value
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

	state_t                state_q;
	logic [OP_W-1:0]       op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      k_q;    // scan index
	logic [CNT_W-1:0]      j_q;    // inner index for dedup
	logic [CNT_W-1:0]      rem_q;
	logic [ST_W-1:0]       st_q;
	logic [VAL_W-1:0]      dout_q;
	logic                  ov_q;

	logic [DATA_WIDTH-1:0] ent [DEPTH];
	always_comb begin
		for (int i = 0; i < DEPTH; i++) ent[i] = cell_data[i*DATA_WIDTH +: DATA_WIDTH];
	end

	logic [DATA_WIDTH-1:0] in_val;
	logic [CNT_W:0]        pos_ext;
	assign in_val  = DATA_WIDTH'(value);
	assign pos_ext = (CNT_W+1)'(position);

	logic [DATA_WIDTH-1:0] ent_k, ent_j;
	assign ent_k = ent[k_q[IDX_W-1:0]];
	assign ent_j = ent[j_q[IDX_W-1:0]];

	assign in_stall  = (state_q != S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign status        = st_q;
	assign data_out      = dout_q;
	assign removed_count = POS_W'(rem_q);
	assign length_after  = POS_W'(len_q);

	logic take;
	assign take = in_valid && !in_stall;

	// cell command, one per cycle
	always_comb begin
		cell_op   = CELL_HOLD;
		sel_idx   = '0;
		ins_value = in_val;
		if (take) begin
			priority if (op == OP_INSERT_AT) begin
				if (pos_ext <= (CNT_W+1)'(len_q) && len_q != CNT_W'(DEPTH)) begin
					cell_op = CELL_INSERT;
					sel_idx = IDX_W'(position);
				end
			end else if (op == OP_DELETE_AT) begin
				if (len_q != '0 && pos_ext < (CNT_W+1)'(len_q)) begin
					cell_op = CELL_COMPACT;
					sel_idx = IDX_W'(position);
				end
			end else if (op == OP_REMOVE_FIRST) begin
				if (len_q != '0) cell_op = CELL_COMPACT;
			end else begin
			end
		end else if (state_q == S_SCAN) begin
			unique case (op_q)
				OP_DELETE_VALUE, OP_DELETE_ALL: begin
					if (k_q < len_q && ent_k == val_q) begin
						cell_op = CELL_COMPACT;
						sel_idx = k_q[IDX_W-1:0];
					end
				end
				OP_DELETE_BEFORE: begin
					if (k_q < len_q && ent_k == val_q) begin
						cell_op = CELL_COMPACT;
						sel_idx = (k_q == '0) ? IDX_W'(len_q - 1'b1) : IDX_W'(k_q - 1'b1);
					end
				end
				OP_DEDUP: begin
					if (j_q < len_q && ent_j == ent_k) begin
						cell_op = CELL_COMPACT;
						sel_idx = j_q[IDX_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			len_q   <= '0;
			op_q    <= '0;
			val_q   <= '0;
			k_q     <= '0;
			j_q     <= '0;
			rem_q   <= '0;
			st_q    <= ST_OK;
			dout_q  <= '0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						op_q   <= op;
						val_q  <= in_val;
						k_q    <= '0;
						j_q    <= CNT_W'(1);
						rem_q  <= '0;
						st_q   <= ST_OK;
						dout_q <= '0;
						priority if (op == OP_INSERT_AT) begin
							if (pos_ext > (CNT_W+1)'(len_q)) st_q <= ST_BADPOS;
							else if (len_q == CNT_W'(DEPTH)) st_q <= ST_FULL;
							else len_q <= len_q + 1'b1;
							ov_q <= 1'b1;
						end else if (op == OP_DELETE_AT) begin
							if (len_q == '0) st_q <= ST_EMPTY;
							else if (pos_ext >= (CNT_W+1)'(len_q)) st_q <= ST_BADPOS;
							else begin
								len_q <= len_q - 1'b1;
								rem_q <= CNT_W'(1);
							end
							ov_q <= 1'b1;
						end else if (op == OP_REMOVE_FIRST || op == OP_REMOVE_LAST) begin
							if (len_q == '0) st_q <= ST_EMPTY;
							else begin
								dout_q <= VAL_W'(op == OP_REMOVE_FIRST ? ent[0]
									: ent[IDX_W'(len_q - 1'b1)]);
								len_q  <= len_q - 1'b1;
								rem_q  <= CNT_W'(1);
							end
							ov_q <= 1'b1;
						end else if (op == OP_DELETE_BEFORE) begin
							if (len_q == CNT_W'(1)) begin
								st_q <= ST_SINGLE;
								ov_q <= 1'b1;
							end else state_q <= S_SCAN;
						end else if (op == OP_DELETE_VALUE || op == OP_DELETE_ALL
								|| op == OP_SEARCH || op == OP_DEDUP) begin
							if (len_q == '0) begin
								st_q <= ST_EMPTY;
								ov_q <= 1'b1;
							end else state_q <= S_SCAN;
						end else begin
							ov_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					unique case (op_q)
						OP_DELETE_VALUE, OP_DELETE_BEFORE, OP_SEARCH: begin
							if (k_q >= len_q) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_OUT;
							end else if (ent_k == val_q) begin
								if (op_q != OP_SEARCH) begin
									len_q <= len_q - 1'b1;
									rem_q <= CNT_W'(1);
								end
								state_q <= S_OUT;
							end else k_q <= k_q + 1'b1;
						end
						OP_DELETE_ALL: begin
							if (k_q >= len_q) begin
								if (rem_q == '0) st_q <= ST_NOTFOUND;
								state_q <= S_OUT;
							end else if (ent_k == val_q) begin
								// hold k: the next element slid into place
								len_q <= len_q - 1'b1;
								rem_q <= rem_q + 1'b1;
							end else k_q <= k_q + 1'b1;
						end
						default: begin // dedup
							if (k_q >= len_q) state_q <= S_OUT;
							else if (j_q >= len_q) begin
								k_q <= k_q + 1'b1;
								j_q <= k_q + CNT_W'(2);
							end else if (ent_j == ent_k) begin
								len_q <= len_q - 1'b1;
								rem_q <= rem_q + 1'b1;
							end else j_q <= j_q + 1'b1;
						end
					endcase
				end
				default: begin // S_OUT: cells settle, then present result
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/ordered_list_engine_unit.sv =====
// Insert, position deletes and remove first/last answer directly from idle; value scans
// walk the list in S_SCAN (one list position per cycle) and dedup compares every pair.
// One command at a time: in_stall stays high during a scan and while a result is unread.
// Reset (arst_n low, async) empties the list; cell contents stay undefined until written.
`default_nettype none
module ordered_list_engine_unit
	import ole_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire [OP_W-1:0]          op,
	input  wire [POS_W-1:0]         position,
	input  wire [VAL_W-1:0]         value,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [ST_W-1:0]         status,
	output logic [VAL_W-1:0]        data_out,
	output logic [POS_W-1:0]        removed_count,
	output logic [POS_W-1:0]        length_after
);
	localparam int unsigned IDX_W = $clog2(DEPTH);

	logic [DEPTH*DATA_WIDTH-1:0] cell_data;
	cell_op_t                    cell_op;
	logic [IDX_W-1:0]            sel_idx;
	logic [DATA_WIDTH-1:0]       ins_value;

	ole_seq #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_seq (
		.clk, .arst_n, .in_valid, .in_stall, .op, .position, .value,
		.out_valid, .out_stall, .status, .data_out, .removed_count, .length_after,
		.cell_data, .cell_op, .sel_idx, .ins_value
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d, right_d;
		if (i == 0) begin : g_l0
			assign left_d = ins_value;
		end else begin : g_l
			assign left_d = cell_data[(i-1)*DATA_WIDTH +: DATA_WIDTH];
		end
		if (i == DEPTH-1) begin : g_rn
			assign right_d = cell_data[i*DATA_WIDTH +: DATA_WIDTH];
		end else begin : g_r
			assign right_d = cell_data[(i+1)*DATA_WIDTH +: DATA_WIDTH];
		end
		ole_cell #(.DATA_WIDTH(DATA_WIDTH), .IDX_W(IDX_W)) u_cell (
			.clk,
			.my_idx(IDX_W'(i)),
			.cell_op, .sel_idx, .ins_value,
			.left_data(left_d), .right_data(right_d),
			.data(cell_data[i*DATA_WIDTH +: DATA_WIDTH])
		);
	end
endmodule
`default_nettype wire

// ===== tb/ordered_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module ordered_list_engine_unit_tb;
	import ole_pkg::*;

	localparam int unsigned LIST_MAX = 16;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] data_out;
		logic [POS_W-1:0] removed_count;
		logic [POS_W-1:0] length_after;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] op = '0;
	logic [POS_W-1:0] position = '0;
	logic [VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ST_W-1:0] status;
	logic [VAL_W-1:0] data_out;
	logic [POS_W-1:0] removed_count;
	logic [POS_W-1:0] length_after;

	ordered_list_engine_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .position(position), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .data_out(data_out),
		.removed_count(removed_count), .length_after(length_after)
	);

	cmd_t pending_cmds[$];
	reply_t expected_replies[$];
	logic [VAL_W-1:0] shadow_list[$];
	int unsigned mismatches = 0;
	int unsigned transfers_in = 0;
	int unsigned transfers_out = 0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	bit stim_done = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		else if (r < 92)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 8);
	endfunction

	function automatic int find_value(logic [VAL_W-1:0] v);
		foreach (shadow_list[k])
			if (shadow_list[k] == v)
				return k;
		return -1;
	endfunction

	// update the shadow list and compute the reply for one command
	function automatic reply_t apply_cmd(cmd_t c);
		reply_t r;
		int idx;
		int unsigned n;
		int unsigned k;
		int unsigned j;
		r = '0;
		n = shadow_list.size();
		case (c.op)
			OP_INSERT_AT: begin
				if (c.position > n)
					r.status = ST_BADPOS;
				else if (n >= LIST_MAX)
					r.status = ST_FULL;
				else
					shadow_list.insert(c.position, c.value);
			end
			OP_DELETE_AT: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else if (c.position >= n)
					r.status = ST_BADPOS;
				else begin
					shadow_list.delete(c.position);
					r.removed_count = 1;
				end
			end
			OP_DELETE_VALUE: begin
				idx = find_value(c.value);
				if (n == 0)
					r.status = ST_EMPTY;
				else if (idx < 0)
					r.status = ST_NOTFOUND;
				else begin
					shadow_list.delete(idx);
					r.removed_count = 1;
				end
			end
			OP_DELETE_BEFORE: begin
				idx = find_value(c.value);
				if (n == 1)
					r.status = ST_SINGLE;
				else if (idx < 0)
					r.status = ST_NOTFOUND;
				else begin
					shadow_list.delete(idx == 0 ? n - 1 : idx - 1);
					r.removed_count = 1;
				end
			end
			OP_DELETE_ALL: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else begin
					k = 0;
					while (k < shadow_list.size()) begin
						if (shadow_list[k] == c.value) begin
							shadow_list.delete(k);
							r.removed_count++;
						end else
							k++;
					end
					if (r.removed_count == 0)
						r.status = ST_NOTFOUND;
				end
			end
			OP_SEARCH: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else if (find_value(c.value) < 0)
					r.status = ST_NOTFOUND;
			end
			OP_REMOVE_FIRST: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else begin
					r.data_out = shadow_list.pop_front();
					r.removed_count = 1;
				end
			end
			OP_REMOVE_LAST: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else begin
					r.data_out = shadow_list.pop_back();
					r.removed_count = 1;
				end
			end
			OP_DEDUP: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else begin
					for (k = 0; k < shadow_list.size(); k++) begin
						j = k + 1;
						while (j < shadow_list.size()) begin
							if (shadow_list[j] == shadow_list[k]) begin
								shadow_list.delete(j);
								r.removed_count++;
							end else
								j++;
						end
					end
				end
			end
			default: ;
		endcase
		r.length_after = POS_W'(shadow_list.size());
		return r;
	endfunction

	function automatic cmd_t make_cmd(int unsigned o, int unsigned p, int unsigned v);
		cmd_t c;
		c.op = OP_W'(o);
		c.position = POS_W'(p);
		c.value = VAL_W'(v);
		return c;
	endfunction

	// small value pool makes matches and duplicates common
	function automatic logic [VAL_W-1:0] rand_value();
		if ($urandom_range(3) != 0)
			return VAL_W'(($urandom_range(7) << 12) | $urandom_range(3));
		return VAL_W'($urandom_range(16'hFFFF));
	endfunction

	function automatic cmd_t rand_cmd(int unsigned bias_insert);
		int unsigned r;
		r = $urandom_range(99);
		if (r < bias_insert)
			return make_cmd(OP_INSERT_AT, $urandom_range(17), rand_value());
		else if (r < 97)
			return make_cmd($urandom_range(8), $urandom_range(17), rand_value());
		return make_cmd($urandom_range(15, 9), $urandom_range(31), $urandom_range(16'hFFFF));
	endfunction

	initial begin
		int unsigned i;
		// empty-list behavior for every op
		for (i = 0; i <= OP_DEDUP; i++)
			pending_cmds.push_back(make_cmd(i, 0, 16'h0000));
		pending_cmds.push_back(make_cmd(OP_INSERT_AT, 1, 16'h1234));
		pending_cmds.push_back(make_cmd(OP_INSERT_AT, 0, 16'hFFFF));
		pending_cmds.push_back(make_cmd(OP_DELETE_BEFORE, 0, 16'hFFFF));
		pending_cmds.push_back(make_cmd(OP_DELETE_VALUE, 0, 16'h0000));
		// fill to full with duplicates, then overflow
		for (i = 0; i < 16; i++)
			pending_cmds.push_back(make_cmd(OP_INSERT_AT, i, (i % 3 == 0) ? 16'hA5A5 : 16'h0000));
		pending_cmds.push_back(make_cmd(OP_INSERT_AT, 16, 16'h5A5A));
		pending_cmds.push_back(make_cmd(OP_INSERT_AT, 17, 16'h5A5A));
		pending_cmds.push_back(make_cmd(OP_DELETE_BEFORE, 0, 16'h0000));
		pending_cmds.push_back(make_cmd(OP_DEDUP, 0, 16'h0000));
		pending_cmds.push_back(make_cmd(OP_DELETE_AT, 31, 16'h0000));
		pending_cmds.push_back(make_cmd(4'hF, 31, 16'hFFFF));
		for (i = 0; i < 950; i++)
			pending_cmds.push_back(rand_cmd((i / 100) % 2 ? 30 : 55));
		stim_done = 1'b1;
	end

	// driver
	always @(posedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				transfers_in++;
				expected_replies.push_back(apply_cmd({op, position, value}));
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0
						&& !(in_valid && !in_stall && pending_cmds.size() == 0)) begin
					c = pending_cmds.pop_front();
					in_valid <= 1'b1;
					op <= c.op;
					position <= c.position;
					value <= c.value;
					in_gap = ((transfers_in / 200) % 2) ? 0 : pick_gap();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		reply_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				transfers_out++;
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: status=%0d data=%h removed=%0d len=%0d",
							status, data_out, removed_count, length_after);
				end else begin
					e = expected_replies.pop_front();
					if (e != {status, data_out, removed_count, length_after}) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
								transfers_out, e.status, e.data_out, e.removed_count,
								e.length_after, status, data_out, removed_count, length_after);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_gap = ((transfers_out / 150) % 2) ? 0 : pick_gap();
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && pending_cmds.size() == 0 && !in_valid
			&& expected_replies.size() == 0);
		repeat (400) @(posedge clk);
		$display("Ran %0d commands over all ops, empty and full lists; %0d results checked.",
			transfers_in, transfers_out);
		if (mismatches == 0 && expected_replies.size() == 0)
			$display("Verification passed");
		else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_replies.size());
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout: %0d commands in, %0d results out", transfers_in, transfers_out);
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/ole_pkg.sv
rtl/core/ole_cell.sv
rtl/core/ole_seq.sv
rtl/core/ordered_list_engine_unit.sv
tb/ordered_list_engine_unit_tb.sv
